[rtl/tlv_message_deframer_macros.svh]
// Assertion macros shared by the TLV message deframer RTL.
`ifndef TLV_MESSAGE_DEFRAMER_MACROS_SVH
`define TLV_MESSAGE_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TLV_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlv deframer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TLV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlv deframer: next-cycle check failed");

`endif

[rtl/tlv_df_pkg.sv]
// Package for the TLV message deframer: field lengths, field codes and shared structs.
`timescale 1ns / 1ps
`default_nettype none

package tlv_df_pkg;

  // Fixed field lengths in bytes
  localparam logic [31:0] NAME_BYTES  = 32'd32;
  localparam logic [31:0] COUNT_BYTES = 32'd4;
  localparam logic [31:0] TYPE_BYTES  = 32'd4;
  localparam logic [31:0] SIZE_BYTES  = 32'd4;

  // Field being received; also the field tag on each result beat
  typedef enum logic [2:0] {
    PH_NAME    = 3'd0,
    PH_COUNT   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_SIZE    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [31:0] field_bytes_seen;
    logic [31:0] item_total;
    logic [31:0] items_started;
    logic [31:0] payload_length;
    logic [31:0] word_assembly;
  } state_t;

  // One result beat
  typedef struct packed {
    phase_t      field_tag;
    logic [7:0]  byte_out;
    logic [31:0] item_index;
    logic [31:0] byte_offset;
    logic        field_done;
    logic [31:0] field_value;
    logic        message_done;
  } result_t;

endpackage

`default_nettype wire

[rtl/tlv_df_step.sv]
// Per-byte deframing logic: tags one byte and computes the next parser state.
`timescale 1ns / 1ps
`default_nettype none

module tlv_df_step (
  input  wire tlv_df_pkg::state_t st,
  input  wire logic [7:0]         rx_byte,
  output tlv_df_pkg::state_t      st_nxt,
  output tlv_df_pkg::result_t     res
);

  tlv_df_pkg::phase_t ph;
  logic [31:0] off;
  logic [31:0] off_inc;
  logic [31:0] flen;
  logic [31:0] idx;
  logic [31:0] wa;
  logic [31:0] value;
  logic        fdone;
  logic        mdone;
  logic        last_item;

  always_comb begin
    // out-of-range phase falls back to the name field
    case (st.phase)
      tlv_df_pkg::PH_NAME,
      tlv_df_pkg::PH_COUNT,
      tlv_df_pkg::PH_TYPE,
      tlv_df_pkg::PH_SIZE,
      tlv_df_pkg::PH_PAYLOAD: ph = st.phase;
      default:                ph = tlv_df_pkg::PH_NAME;
    endcase

    off     = st.field_bytes_seen;
    off_inc = off + 32'd1;

    // item index holds for type, size and payload bytes
    if ((ph inside {tlv_df_pkg::PH_TYPE, tlv_df_pkg::PH_SIZE, tlv_df_pkg::PH_PAYLOAD}) &&
        (st.items_started != 32'd0)) begin
      idx = st.items_started - 32'd1;
    end else begin
      idx = 32'd0;
    end

    // field length
    case (ph)
      tlv_df_pkg::PH_COUNT:   flen = tlv_df_pkg::COUNT_BYTES;
      tlv_df_pkg::PH_TYPE:    flen = tlv_df_pkg::TYPE_BYTES;
      tlv_df_pkg::PH_SIZE:    flen = tlv_df_pkg::SIZE_BYTES;
      tlv_df_pkg::PH_PAYLOAD: flen = st.payload_length;
      default:                flen = tlv_df_pkg::NAME_BYTES;
    endcase

    // little-endian word assembly for count, type and size
    wa = st.word_assembly;
    if ((ph inside {tlv_df_pkg::PH_COUNT, tlv_df_pkg::PH_TYPE, tlv_df_pkg::PH_SIZE}) &&
        (off < 32'd4)) begin
      wa = wa | ({24'd0, rx_byte} << {off[1:0], 3'b000});
    end

    last_item = (st.items_started == st.item_total);

    st_nxt = st;
    value  = 32'd0;
    fdone  = 1'b0;
    mdone  = 1'b0;

    if (off_inc >= flen) begin
      // this byte closes the field
      fdone                   = 1'b1;
      st_nxt.field_bytes_seen = 32'd0;
      st_nxt.word_assembly    = 32'd0;
      case (ph)
        tlv_df_pkg::PH_COUNT: begin
          value                = wa;
          st_nxt.item_total    = wa;
          if (wa == 32'd0) begin
            // empty message ends here
            st_nxt.phase         = tlv_df_pkg::PH_NAME;
            st_nxt.items_started = 32'd0;
            mdone                = 1'b1;
          end else begin
            st_nxt.phase         = tlv_df_pkg::PH_TYPE;
            st_nxt.items_started = 32'd1;
          end
        end
        tlv_df_pkg::PH_TYPE: begin
          value        = wa;
          st_nxt.phase = tlv_df_pkg::PH_SIZE;
        end
        tlv_df_pkg::PH_SIZE: begin
          value                 = wa;
          st_nxt.payload_length = wa;
          if (wa != 32'd0) begin
            st_nxt.phase = tlv_df_pkg::PH_PAYLOAD;
          end else if (last_item) begin
            // empty payload on the last item ends the message
            st_nxt.phase          = tlv_df_pkg::PH_NAME;
            st_nxt.item_total     = 32'd0;
            st_nxt.items_started  = 32'd0;
            st_nxt.payload_length = 32'd0;
            mdone                 = 1'b1;
          end else begin
            st_nxt.phase         = tlv_df_pkg::PH_TYPE;
            st_nxt.items_started = st.items_started + 32'd1;
          end
        end
        tlv_df_pkg::PH_PAYLOAD: begin
          if (last_item) begin
            st_nxt.phase          = tlv_df_pkg::PH_NAME;
            st_nxt.item_total     = 32'd0;
            st_nxt.items_started  = 32'd0;
            st_nxt.payload_length = 32'd0;
            mdone                 = 1'b1;
          end else begin
            st_nxt.phase         = tlv_df_pkg::PH_TYPE;
            st_nxt.items_started = st.items_started + 32'd1;
          end
        end
        default: begin
          st_nxt.phase = tlv_df_pkg::PH_COUNT;
        end
      endcase
    end else begin
      st_nxt.field_bytes_seen = off_inc;
      st_nxt.phase            = ph;
      st_nxt.word_assembly    = wa;
    end

    res.field_tag    = ph;
    res.byte_out     = rx_byte;
    res.item_index   = idx;
    res.byte_offset  = off;
    res.field_done   = fdone;
    res.field_value  = value;
    res.message_done = mdone;
  end

endmodule

`default_nettype wire

[rtl/tlv_message_deframer.sv]
// Top level of the TLV message deframer: input register, parser state and result register.
//
//   channel  dir  handshake           beat contents
//   in_      in   in_valid/in_stall   in_rx_byte
//   out_     out  out_valid/out_stall tag, byte, item index, offset, done flags, value
//
// One byte per cycle while out_stall is low; each byte passes both registers in order.
// The 32-bit offset add and compare in the step logic set the clock path.
// rst_n is synchronous: the parser returns to the name field with all counts at zero.
// While out_stall is high the result holds; one more byte waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module tlv_message_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_field_tag,
  output logic [7:0]       out_byte_out,
  output logic [31:0]      out_item_index,
  output logic [31:0]      out_byte_offset,
  output logic             out_field_done,
  output logic [31:0]      out_field_value,
  output logic             out_message_done
);

`include "tlv_message_deframer_macros.svh"

  logic                in_valid_r;
  logic                in_valid_nxt;
  logic [7:0]          in_byte_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  tlv_df_pkg::result_t out_res_r;
  tlv_df_pkg::result_t step_res;
  tlv_df_pkg::state_t  st_r;
  tlv_df_pkg::state_t  st_nxt;
  logic                in_take;
  logic                advance;

  // beat moves from input register to result register
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  tlv_df_step u_step (
    .st      (st_r),
    .rx_byte (in_byte_r),
    .st_nxt  (st_nxt),
    .res     (step_res)
  );

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: tlv_df_pkg::PH_NAME, default: '0};
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_field_tag    = out_res_r.field_tag;
  assign out_byte_out     = out_res_r.byte_out;
  assign out_item_index   = out_res_r.item_index;
  assign out_byte_offset  = out_res_r.byte_offset;
  assign out_field_done   = out_res_r.field_done;
  assign out_field_value  = out_res_r.field_value;
  assign out_message_done = out_res_r.message_done;

  // a message end is always a field end
  `TLV_ASSERT_IMPLIES(a_msg_ends_field, out_valid_r && out_res_r.message_done, out_res_r.field_done)

  // name and count beats belong to no item
  `TLV_ASSERT_IMPLIES(a_hdr_no_item, out_valid_r && (out_res_r.field_tag == tlv_df_pkg::PH_NAME || out_res_r.field_tag == tlv_df_pkg::PH_COUNT), out_res_r.item_index == 32'd0)

  // after a message end the parser is back at a clean name field
  `TLV_ASSERT_NEXT(a_msg_restart, advance && step_res.message_done, st_r.phase == tlv_df_pkg::PH_NAME && st_r.items_started == 32'd0 && st_r.field_bytes_seen == 32'd0)

endmodule

`default_nettype wire
